[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the core
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define WPC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define WPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/wpc_pkg.sv]
// ---------------------------------------------------------------------------
// wpc_pkg
// shared types, constants and tables of the waypoint heading controller
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wpc_pkg;

  localparam int PATH_DEPTH   = 256;
  localparam int ADDR_W       = $clog2(PATH_DEPTH);
  localparam int CNT_W        = $clog2(PATH_DEPTH + 1);
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int ITER_W       = $clog2(TABLE_LEN);

  localparam int DIFF_W = 33;
  localparam int XY_W   = 46;
  localparam int Z_W    = 35;
  localparam int ANG_W  = 16;
  localparam int TRIG_W = 31;

  localparam logic signed [Z_W-1:0]  PI_Q30      = 35'sd3373259426;
  localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [XY_W-1:0] GAIN_Q30    = 46'sd652032874;

  localparam logic signed [31:0] ATAN_TAB [TABLE_LEN] = '{
    32'sd843314856, 32'sd497837829, 32'sd263043836, 32'sd133525158,
    32'sd67021686,  32'sd33543515,  32'sd16775850,  32'sd8388437,
    32'sd4194282,   32'sd2097149,   32'sd1048575,   32'sd524287,
    32'sd262143,    32'sd131071,    32'sd65535,     32'sd32767,
    32'sd16383,     32'sd8191,      32'sd4095,      32'sd2047,
    32'sd1023,      32'sd511,       32'sd255,       32'sd127
  };

  localparam logic MODE_VECTOR = 1'b0;
  localparam logic MODE_ROTATE = 1'b1;

  typedef struct packed {
    logic start;
    logic mode;
  } cordic_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_sts_t;

endpackage

`default_nettype wire

[rtl/core/waypoint_heading_p_controller_core.sv]
// ---------------------------------------------------------------------------
// waypoint_heading_p_controller_core
// pose and waypoint path keeper with proportional heading and velocity output
// ---------------------------------------------------------------------------
// Input words (in_valid/in_ready) carry an opcode with position, heading and
// path_start fields: pose update, waypoint push, clear path, tick, start, stop.
// Start and stop produce a zero command word through the output register. A
// tick, when tracking with a pose and a nonempty path, reads the path memory,
// runs the shared cordic for the leg bearing (only when a second waypoint
// follows), for the target bearing and, unless the heading error exceeds the
// turn limit going forward (the tick then ends with no result), for cos/sin of
// the yaw, then steps through M0 to M7 on one shared multiplier. A cordic call
// runs scaling (vectoring only), 16 rotations and finish; in_ready is high only
// in the idle state. Results sit in an output register (out_valid/out_ready); a
// stalled receiver holds the word, and the block accepts words until a new
// result waits in ST_OUT, held with in_ready low until the register frees up.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
// Synchronous reset clears pose, tracking and the path pointers and restores
// default gains; the path memory itself is not cleared.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module waypoint_heading_p_controller_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [14:0] heading,
  input  logic               path_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] vel_yaw,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import wpc_pkg::*;

  localparam logic [2:0] OP_POSE  = 3'd0;
  localparam logic [2:0] OP_WAYPT = 3'd1;
  localparam logic [2:0] OP_CLEAR = 3'd2;
  localparam logic [2:0] OP_TICK  = 3'd3;
  localparam logic [2:0] OP_START = 3'd4;
  localparam logic [2:0] OP_STOP  = 3'd5;

  localparam logic [2:0] REG_GAIN_X   = 3'd0;
  localparam logic [2:0] REG_GAIN_Y   = 3'd1;
  localparam logic [2:0] REG_GAIN_YAW = 3'd2;
  localparam logic [2:0] REG_TURN     = 3'd3;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_RD0    = 5'd1;
  localparam logic [4:0] ST_RD1    = 5'd2;
  localparam logic [4:0] ST_LEG_W  = 5'd3;
  localparam logic [4:0] ST_BEAR   = 5'd4;
  localparam logic [4:0] ST_BEAR_W = 5'd5;
  localparam logic [4:0] ST_ERR    = 5'd6;
  localparam logic [4:0] ST_ROT_W  = 5'd7;
  localparam logic [4:0] ST_M0     = 5'd8;
  localparam logic [4:0] ST_M1     = 5'd9;
  localparam logic [4:0] ST_M2     = 5'd10;
  localparam logic [4:0] ST_M3     = 5'd11;
  localparam logic [4:0] ST_M4     = 5'd12;
  localparam logic [4:0] ST_M5     = 5'd13;
  localparam logic [4:0] ST_M6     = 5'd14;
  localparam logic [4:0] ST_M7     = 5'd15;
  localparam logic [4:0] ST_OUT    = 5'd16;

  localparam int OPA_W  = 35;
  localparam int OPB_W  = 31;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int ERR_W  = 18;

  localparam logic signed [ANG_W-1:0] DEADBAND_Q12 = 16'sd4;
  localparam logic signed [ERR_W-1:0] HALF_PI_Q12  = 18'sd6434;
  localparam logic signed [ERR_W-1:0] TWO_PI_Q12   = 18'sd25736;

  function automatic logic signed [ANG_W-1:0] dead_band(input logic signed [ANG_W-1:0] a);
    return (a >= -DEADBAND_Q12 && a <= DEADBAND_Q12) ? '0 : a;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-32:0] top;
    top = v[PROD_W-1:31];
    if (&top || ~|top) begin
      return v[31:0];
    end
    return v[PROD_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  // control
  logic [4:0]         state;
  logic [15:0]        gain_x;
  logic [15:0]        gain_y;
  logic [15:0]        gain_yaw;
  logic [14:0]        turn_limit;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [14:0] pose_yaw;
  logic               pose_seen;
  logic               tracking_on;
  logic [ADDR_W-1:0]  fifo_head;
  logic [CNT_W-1:0]   fifo_count;

  // datapath
  logic signed [31:0]         tx;
  logic signed [31:0]         ty;
  logic                       fwd;
  logic signed [DIFF_W-1:0]   xerr;
  logic signed [DIFF_W-1:0]   yerr;
  logic signed [ANG_W-1:0]    bear;
  logic signed [ERR_W-1:0]    err;
  logic signed [TRIG_W-1:0]   cos_r;
  logic signed [TRIG_W-1:0]   sin_r;
  logic signed [OPA_W-1:0]    ex;
  logic signed [OPA_W-1:0]    ey;
  logic signed [ACC_W-1:0]    acc;
  logic signed [PROD_W-1:0]   prod;
  logic signed [31:0]         res_x;
  logic signed [31:0]         res_y;
  logic signed [31:0]         res_yaw;

  // path memory
  logic [63:0]        wp_mem [PATH_DEPTH];
  logic [63:0]        rdata;
  logic               rd_en;
  logic [ADDR_W-1:0]  raddr;
  logic               wr_en;
  logic [ADDR_W-1:0]  waddr;

  // comb
  logic                     accept;
  logic                     tick_ok;
  logic                     out_load;
  logic [ADDR_W-1:0]        head_inc;
  logic [ADDR_W-1:0]        eff_head;
  logic [CNT_W-1:0]         eff_count;
  logic [CNT_W:0]           slot_sum;
  logic                     push_ok;
  logic signed [31:0]       nx;
  logic signed [31:0]       ny;
  logic signed [DIFF_W-1:0] xerr_c;
  logic signed [DIFF_W-1:0] yerr_c;
  logic signed [ANG_W-1:0]  yaw_db;
  logic signed [ERR_W-1:0]  bear_e;
  logic signed [ERR_W-1:0]  yaw_e;
  logic signed [ERR_W-1:0]  err_c;
  logic signed [ERR_W-1:0]  tl_e;
  logic signed [ANG_W-1:0]  tl_a;
  logic                     suppress;
  logic                     leg_back;
  logic signed [OPA_W-1:0]  op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [ACC_W-1:0]  ex_sum;
  logic signed [ACC_W-1:0]  ey_sum;
  logic signed [PROD_W-1:0] rnd16;
  logic signed [PROD_W-1:0] rnd12;

  cordic_req_t              cq;
  cordic_sts_t              cs;
  logic signed [DIFF_W-1:0] cq_x;
  logic signed [DIFF_W-1:0] cq_y;
  logic signed [ANG_W-1:0]  c_angle;
  logic signed [TRIG_W-1:0] c_cos;
  logic signed [TRIG_W-1:0] c_sin;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign tick_ok  = tracking_on && pose_seen && (fifo_count != '0);
  assign out_load = (state == ST_OUT) && (!out_valid || out_ready);
  assign head_inc = (fifo_head == ADDR_W'(PATH_DEPTH - 1)) ? '0 : fifo_head + ADDR_W'(1);

  assign eff_head  = path_start ? '0 : fifo_head;
  assign eff_count = path_start ? '0 : fifo_count;
  assign push_ok   = (eff_count < CNT_W'(PATH_DEPTH));
  assign slot_sum  = (CNT_W + 1)'(eff_head) + (CNT_W + 1)'(eff_count);
  assign waddr     = (slot_sum >= (CNT_W + 1)'(PATH_DEPTH))
                   ? ADDR_W'(slot_sum - (CNT_W + 1)'(PATH_DEPTH)) : ADDR_W'(slot_sum);
  assign wr_en     = accept && (opcode == OP_WAYPT) && push_ok;

  assign nx     = rdata[63:32];
  assign ny     = rdata[31:0];
  assign xerr_c = DIFF_W'(tx) - DIFF_W'(pose_x);
  assign yerr_c = DIFF_W'(ty) - DIFF_W'(pose_y);

  assign yaw_db = dead_band(ANG_W'(pose_yaw));
  assign bear_e = ERR_W'(bear);
  assign yaw_e  = ERR_W'(yaw_db);
  assign tl_e   = $signed({3'b000, turn_limit});
  assign tl_a   = $signed({1'b0, turn_limit});

  always_comb begin
    if (bear_e >= HALF_PI_Q12 && yaw_e <= -HALF_PI_Q12) begin
      err_c = bear_e - yaw_e - TWO_PI_Q12;
    end else if (bear_e <= -HALF_PI_Q12 && yaw_e >= HALF_PI_Q12) begin
      err_c = bear_e - yaw_e + TWO_PI_Q12;
    end else begin
      err_c = bear_e - yaw_e;
    end
  end

  assign suppress = fwd && (err_c > tl_e || err_c < -tl_e);
  assign leg_back = (c_angle > tl_a) || (c_angle < -tl_a);

  always_comb begin
    rd_en   = 1'b0;
    raddr   = fifo_head;
    cq.start = 1'b0;
    cq.mode  = MODE_VECTOR;
    cq_x    = xerr_c;
    cq_y    = yerr_c;
    case (state)
      ST_IDLE: begin
        if (accept && opcode == OP_TICK && tick_ok) begin
          rd_en = 1'b1;
        end
      end
      ST_RD0: begin
        if (fifo_count > CNT_W'(1)) begin
          rd_en = 1'b1;
          raddr = head_inc;
        end
      end
      ST_RD1: begin
        cq.start = 1'b1;
        cq_x     = DIFF_W'(nx) - DIFF_W'(tx);
        cq_y     = DIFF_W'(ny) - DIFF_W'(ty);
      end
      ST_BEAR: cq.start = 1'b1;
      ST_ERR: begin
        if (!suppress) begin
          cq.start = 1'b1;
          cq.mode  = MODE_ROTATE;
        end
      end
      default: begin
      end
    endcase
  end

  wpc_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .req     (cq),
    .vec_x   (cq_x),
    .vec_y   (cq_y),
    .rot_ang (yaw_db[14:0]),
    .sts     (cs),
    .angle   (c_angle),
    .cos_v   (c_cos),
    .sin_v   (c_sin)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wp_mem[waddr] <= {pos_x, pos_y};
    end
    if (rd_en) begin
      rdata <= wp_mem[raddr];
    end
  end

  // shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      ST_M0: begin op_a = OPA_W'(xerr); op_b = cos_r; end
      ST_M1: begin op_a = OPA_W'(yerr); op_b = sin_r; end
      ST_M2: begin op_a = OPA_W'(xerr); op_b = sin_r; end
      ST_M3: begin op_a = OPA_W'(yerr); op_b = cos_r; end
      ST_M4: begin op_a = ex;           op_b = $signed({15'd0, gain_x}); end
      ST_M5: begin op_a = ey;           op_b = $signed({15'd0, gain_y}); end
      ST_M6: begin op_a = OPA_W'(err);  op_b = $signed({15'd0, gain_yaw}); end
      default: begin
      end
    endcase
  end

  assign ex_sum = (acc - ACC_W'(prod) + ACC_W'(64'sd1 <<< 27)) >>> 28;
  assign ey_sum = (acc + ACC_W'(prod) + ACC_W'(64'sd1 <<< 27)) >>> 28;
  assign rnd16  = (prod + PROD_W'(64'sd1 <<< 15)) >>> 16;
  assign rnd12  = (prod + PROD_W'(64'sd1 <<< 11)) >>> 12;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      gain_x      <= 16'd655;
      gain_y      <= 16'd655;
      gain_yaw    <= 16'd655;
      turn_limit  <= 15'd8192;
      pose_x      <= '0;
      pose_y      <= '0;
      pose_yaw    <= '0;
      pose_seen   <= 1'b0;
      tracking_on <= 1'b0;
      fifo_head   <= '0;
      fifo_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_X:   gain_x     <= cfg_data;
          REG_GAIN_Y:   gain_y     <= cfg_data;
          REG_GAIN_YAW: gain_yaw   <= cfg_data;
          REG_TURN:     turn_limit <= cfg_data[14:0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (opcode)
              OP_POSE: begin
                pose_x    <= pos_x;
                pose_y    <= pos_y;
                pose_yaw  <= heading;
                pose_seen <= 1'b1;
              end
              OP_WAYPT: begin
                fifo_head  <= eff_head;
                fifo_count <= push_ok ? eff_count + CNT_W'(1) : eff_count;
              end
              OP_CLEAR: begin
                fifo_head  <= '0;
                fifo_count <= '0;
              end
              OP_TICK: begin
                if (tick_ok) begin
                  state <= ST_RD0;
                end
              end
              OP_START: begin
                tracking_on <= 1'b1;
                state       <= ST_OUT;
              end
              OP_STOP: begin
                tracking_on <= 1'b0;
                fifo_head   <= '0;
                fifo_count  <= '0;
                state       <= ST_OUT;
              end
              default: begin
              end
            endcase
          end
        end
        ST_RD0: begin
          if (fifo_count > CNT_W'(1)) begin
            fifo_head  <= head_inc;
            fifo_count <= fifo_count - CNT_W'(1);
            state      <= ST_RD1;
          end else begin
            state <= ST_BEAR;
          end
        end
        ST_RD1:    state <= ST_LEG_W;
        ST_LEG_W:  if (cs.done) state <= ST_BEAR;
        ST_BEAR:   state <= ST_BEAR_W;
        ST_BEAR_W: if (cs.done) state <= ST_ERR;
        ST_ERR:    state <= suppress ? ST_IDLE : ST_ROT_W;
        ST_ROT_W:  if (cs.done) state <= ST_M0;
        ST_M0:     state <= ST_M1;
        ST_M1:     state <= ST_M2;
        ST_M2:     state <= ST_M3;
        ST_M3:     state <= ST_M4;
        ST_M4:     state <= ST_M5;
        ST_M5:     state <= ST_M6;
        ST_M6:     state <= ST_M7;
        ST_M7:     state <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    case (state)
      ST_IDLE: begin
        if (accept && (opcode == OP_START || opcode == OP_STOP)) begin
          res_x   <= '0;
          res_y   <= '0;
          res_yaw <= '0;
        end
      end
      ST_RD0: begin
        tx  <= nx;
        ty  <= ny;
        fwd <= 1'b1;
      end
      ST_LEG_W:  if (cs.done) fwd <= !leg_back;
      ST_BEAR: begin
        xerr <= xerr_c;
        yerr <= yerr_c;
      end
      ST_BEAR_W: if (cs.done) bear <= dead_band(c_angle);
      ST_ERR:    err <= err_c;
      ST_ROT_W: begin
        if (cs.done) begin
          cos_r <= c_cos;
          sin_r <= c_sin;
        end
      end
      ST_M1: acc     <= ACC_W'(prod);
      ST_M2: ex      <= ex_sum[OPA_W-1:0];
      ST_M3: acc     <= ACC_W'(prod);
      ST_M4: ey      <= ey_sum[OPA_W-1:0];
      ST_M5: res_x   <= sat32(rnd16);
      ST_M6: res_y   <= sat32(rnd16);
      ST_M7: res_yaw <= sat32(rnd12);
      ST_OUT: begin
        if (out_load) begin
          vel_x   <= res_x;
          vel_y   <= res_y;
          vel_yaw <= res_yaw;
        end
      end
      default: begin
      end
    endcase
  end

  `WPC_ASSERT(a_cordic_start_idle, clk, rst, cq.start |-> !cs.busy, "cordic started while busy")
  `WPC_ASSERT(a_count_bound, clk, rst, fifo_count <= CNT_W'(PATH_DEPTH), "path count overflow")
  `WPC_ASSERT(a_empty_tick, clk, rst, (accept && opcode == OP_TICK && fifo_count == '0) |=> (state == ST_IDLE), "tick on empty path left idle")
  `WPC_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == ST_IDLE && !out_valid), "not idle after reset")

endmodule

`default_nettype wire

[rtl/core/wpc_cordic.sv]
// ---------------------------------------------------------------------------
// wpc_cordic
// shared iterative cordic: atan2 in vectoring mode, cos/sin in rotation mode
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wpc_cordic (
  input  logic                                 clk,
  input  logic                                 rst,
  input  wpc_pkg::cordic_req_t                 req,
  input  logic signed [wpc_pkg::DIFF_W-1:0]    vec_x,
  input  logic signed [wpc_pkg::DIFF_W-1:0]    vec_y,
  input  logic signed [14:0]                   rot_ang,
  output wpc_pkg::cordic_sts_t                 sts,
  output logic signed [wpc_pkg::ANG_W-1:0]     angle,
  output logic signed [wpc_pkg::TRIG_W-1:0]    cos_v,
  output logic signed [wpc_pkg::TRIG_W-1:0]    sin_v
);
  import wpc_pkg::*;

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_NORM = 2'd1;
  localparam logic [1:0] C_ITER = 2'd2;
  localparam logic [1:0] C_DONE = 2'd3;

  localparam logic signed [XY_W-1:0] LIM4 = XY_W'(64'sd1 <<< 36);
  localparam logic signed [XY_W-1:0] LIM1 = XY_W'(64'sd1 <<< 40);

  logic [1:0]              state;
  logic                    mode;
  logic                    neg;
  logic [ITER_W-1:0]       iter;
  logic signed [XY_W-1:0]  x;
  logic signed [XY_W-1:0]  y;
  logic signed [Z_W-1:0]   z;

  logic signed [XY_W-1:0]  vx_ext;
  logic signed [XY_W-1:0]  vy_ext;
  logic signed [Z_W-1:0]   z_rot;
  logic signed [XY_W-1:0]  dx;
  logic signed [XY_W-1:0]  dy;
  logic signed [Z_W-1:0]   tab;
  logic                    up;
  logic                    small4;
  logic                    small1;
  logic signed [Z_W-1:0]   z_rnd;
  logic signed [XY_W-1:0]  xs;
  logic signed [XY_W-1:0]  ys;
  logic signed [XY_W-1:0]  x_rnd;
  logic signed [XY_W-1:0]  y_rnd;

  assign vx_ext = XY_W'(vec_x);
  assign vy_ext = XY_W'(vec_y);
  assign z_rot  = Z_W'(rot_ang) <<< 18;
  assign dx     = y >>> iter;
  assign dy     = x >>> iter;
  assign tab    = Z_W'(ATAN_TAB[iter]);
  assign up     = (mode == MODE_VECTOR) ? (y > 0) : (z < 0);
  assign small4 = (x > -LIM4) && (x < LIM4) && (y > -LIM4) && (y < LIM4);
  assign small1 = (x > -LIM1) && (x < LIM1) && (y > -LIM1) && (y < LIM1);

  assign z_rnd = (z + Z_W'(64'sd1 <<< 17)) >>> 18;
  assign xs    = neg ? -x : x;
  assign ys    = neg ? -y : y;
  assign x_rnd = (xs + XY_W'(2)) >>> 2;
  assign y_rnd = (ys + XY_W'(2)) >>> 2;
  assign angle = z_rnd[ANG_W-1:0];
  assign cos_v = x_rnd[TRIG_W-1:0];
  assign sin_v = y_rnd[TRIG_W-1:0];

  assign sts.busy = (state != C_IDLE);
  assign sts.done = (state == C_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      case (state)
        C_IDLE: begin
          if (req.start) begin
            if (req.mode == MODE_ROTATE) begin
              state <= C_ITER;
            end else if (vec_x == '0 && vec_y == '0) begin
              state <= C_DONE;
            end else begin
              state <= C_NORM;
            end
          end
        end
        C_NORM: begin
          if (!small1) begin
            state <= C_ITER;
          end
        end
        C_ITER: begin
          if (iter == ITER_W'(CORDIC_STEPS - 1)) begin
            state <= C_DONE;
          end
        end
        C_DONE: state <= C_IDLE;
        default: state <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        iter <= '0;
        mode <= req.mode;
        neg  <= 1'b0;
        if (req.mode == MODE_ROTATE) begin
          x <= GAIN_Q30;
          y <= '0;
          if (z_rot > HALF_PI_Q30) begin
            z   <= z_rot - PI_Q30;
            neg <= 1'b1;
          end else if (z_rot < -HALF_PI_Q30) begin
            z   <= z_rot + PI_Q30;
            neg <= 1'b1;
          end else begin
            z <= z_rot;
          end
        end else if (vec_x < 0) begin
          x <= -vx_ext;
          y <= -vy_ext;
          z <= (vec_y >= 0) ? PI_Q30 : -PI_Q30;
        end else begin
          x <= vx_ext;
          y <= vy_ext;
          z <= '0;
        end
      end
      C_NORM: begin
        if (small4) begin
          x <= x <<< 4;
          y <= y <<< 4;
        end else if (small1) begin
          x <= x <<< 1;
          y <= y <<< 1;
        end
      end
      C_ITER: begin
        iter <= iter + ITER_W'(1);
        if (up) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + tab;
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - tab;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[sim/waypoint_heading_p_controller_core_tb.sv]
// ---------------------------------------------------------------------------
// waypoint_heading_p_controller_core_tb
// drives pose, waypoint and control words into the controller core, predicts
// each velocity command word with a local fixed point model and compares it
// with the block output, under random gaps and receiver stalls
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module waypoint_heading_p_controller_core_tb;

  localparam logic [2:0] OP_POSE  = 3'd0;
  localparam logic [2:0] OP_WAYPT = 3'd1;
  localparam logic [2:0] OP_CLEAR = 3'd2;
  localparam logic [2:0] OP_TICK  = 3'd3;
  localparam logic [2:0] OP_START = 3'd4;
  localparam logic [2:0] OP_STOP  = 3'd5;
  localparam logic [2:0] OP_NONE6 = 3'd6;
  localparam logic [2:0] OP_NONE7 = 3'd7;

  localparam logic [2:0] REG_GAIN_X  = 3'd0;
  localparam logic [2:0] REG_GAIN_Y  = 3'd1;
  localparam logic [2:0] REG_GAIN_YAW = 3'd2;
  localparam logic [2:0] REG_TURN    = 3'd3;
  localparam logic [2:0] REG_BAD     = 3'd6;

  localparam longint PI_Q30L      = 64'sd3373259426;
  localparam longint HALF_PI_Q30L = 64'sd1686629713;
  localparam longint GAIN_Q30L    = 64'sd652032874;
  localparam longint NORM_LIM     = 64'sd1 << 40;
  localparam int     HALF_PI_Q12  = 6434;
  localparam int     TWO_PI_Q12   = 25736;
  localparam int     DEAD_Q12     = 4;
  localparam int     DEPTH        = 256;
  localparam int     STEPS        = 16;
  localparam int     EXP_DEPTH    = 256;

  localparam longint ANGLE_TAB [16] = '{
    64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
    64'sd67021686,  64'sd33543515,  64'sd16775850,  64'sd8388437,
    64'sd4194282,   64'sd2097149,   64'sd1048575,   64'sd524287,
    64'sd262143,    64'sd131071,    64'sd65535,     64'sd32767
  };

  typedef struct {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vw;
  } cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] opcode = '0;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic signed [14:0] heading = '0;
  logic path_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] vel_x, vel_y, vel_yaw;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // predictor state
  longint unsigned m_gx, m_gy, m_gw, m_turn;
  longint m_px, m_py;
  int m_yaw;
  bit m_seen, m_track;
  logic [63:0] m_path [DEPTH];
  int m_head, m_count;

  // expected command words, written by the predictor, read by the checker
  cmd_t exp_mem [EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;
  int errors = 0;
  int n_items = 0;
  int n_cmds = 0;
  bit hold_off = 1'b0;

  always #1 clk = ~clk;

  waypoint_heading_p_controller_core DUT (.*);

  function automatic longint asr_round(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint labs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int bearing_q12(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_Q30L : -PI_Q30L;
      x = -x;
      y = -y;
    end
    while (labs(x) < NORM_LIM && labs(y) < NORM_LIM) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ANGLE_TAB[i];
      end else begin
        x -= dx; y += dy; z -= ANGLE_TAB[i];
      end
    end
    return int'(asr_round(z, 18));
  endfunction

  function automatic void yaw_cos_sin(int ang, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit neg;
    z = longint'(ang) * 262144;
    x = GAIN_Q30L;
    y = 0;
    neg = 0;
    if (z > HALF_PI_Q30L) begin
      z -= PI_Q30L; neg = 1;
    end else if (z < -HALF_PI_Q30L) begin
      z += PI_Q30L; neg = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ANGLE_TAB[i];
      end else begin
        x += dx; y -= dy; z += ANGLE_TAB[i];
      end
    end
    if (neg) begin
      x = -x; y = -y;
    end
    c = asr_round(x, 2);
    s = asr_round(y, 2);
  endfunction

  function automatic int deadband(int a);
    return (a >= -DEAD_Q12 && a <= DEAD_Q12) ? 0 : a;
  endfunction

  function automatic void push_cmd(longint vx, longint vy, longint vw);
    cmd_t e;
    e.vx = 32'(sat32(vx));
    e.vy = 32'(sat32(vy));
    e.vw = 32'(sat32(vw));
    exp_mem[exp_wr % EXP_DEPTH] = e;
    exp_wr++;
  endfunction

  function automatic void predict_tick();
    longint tx, ty, nx, ny, xerr, yerr, c, s, ex, ey;
    int bear, yaw, err, leg;
    bit fwd;
    fwd = 1;
    if (!m_track || !m_seen || m_count == 0) return;
    tx = longint'($signed(m_path[m_head][63:32]));
    ty = longint'($signed(m_path[m_head][31:0]));
    if (m_count > 1) begin
      m_head = (m_head + 1) % DEPTH;
      m_count--;
      nx = longint'($signed(m_path[m_head][63:32]));
      ny = longint'($signed(m_path[m_head][31:0]));
      leg = bearing_q12(nx - tx, ny - ty);
      if (labs(leg) > longint'(m_turn)) fwd = 0;
    end
    xerr = tx - m_px;
    yerr = ty - m_py;
    bear = deadband(bearing_q12(xerr, yerr));
    yaw = deadband(m_yaw);
    if (bear >= HALF_PI_Q12 && yaw <= -HALF_PI_Q12) err = bear - yaw - TWO_PI_Q12;
    else if (bear <= -HALF_PI_Q12 && yaw >= HALF_PI_Q12) err = bear - yaw + TWO_PI_Q12;
    else err = bear - yaw;
    if (fwd && labs(err) > longint'(m_turn)) return;
    yaw_cos_sin(yaw, c, s);
    ex = asr_round(c * xerr - s * yerr, 28);
    ey = asr_round(s * xerr + c * yerr, 28);
    push_cmd(asr_round(longint'(m_gx) * ex, 16), asr_round(longint'(m_gy) * ey, 16),
             asr_round(longint'(m_gw) * err, 12));
  endfunction

  function automatic void predict_word(logic [2:0] op, logic signed [31:0] x,
                                       logic signed [31:0] y, logic signed [14:0] h,
                                       logic ps);
    case (op)
      OP_POSE: begin
        m_px = x; m_py = y; m_yaw = h; m_seen = 1;
      end
      OP_WAYPT: begin
        if (ps) begin
          m_head = 0; m_count = 0;
        end
        if (m_count < DEPTH) begin
          m_path[(m_head + m_count) % DEPTH] = {x, y};
          m_count++;
        end
      end
      OP_CLEAR: begin
        m_head = 0; m_count = 0;
      end
      OP_TICK: predict_tick();
      OP_START: begin
        m_track = 1; push_cmd(0, 0, 0);
      end
      OP_STOP: begin
        m_track = 0; m_head = 0; m_count = 0; push_cmd(0, 0, 0);
      end
      default: ;
    endcase
  endfunction

  // valid stays high after acceptance; the next word or an idle stretch replaces it
  task automatic send_word(logic [2:0] op, logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [14:0] h, logic ps);
    in_valid <= 1'b1;
    opcode <= op;
    pos_x <= x;
    pos_y <= y;
    heading <= h;
    path_start <= ps;
    do @(posedge clk); while (!in_ready);
    predict_word(op, x, y, h, ps);
    n_items++;
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GAIN_X:   m_gx = val;
      REG_GAIN_Y:   m_gy = val;
      REG_GAIN_YAW: m_gw = val;
      REG_TURN:     m_turn = val[14:0];
      default: ;
    endcase
  endtask

  task automatic set_gains(logic [15:0] gx, logic [15:0] gy, logic [15:0] gw,
                           logic [15:0] tl);
    drain();
    write_reg(REG_GAIN_X, gx);
    write_reg(REG_GAIN_Y, gy);
    write_reg(REG_GAIN_YAW, gw);
    write_reg(REG_TURN, tl);
  endtask

  function automatic logic signed [31:0] rand_pos(int spread);
    case ($urandom_range(0, 3))
      0: return $signed($urandom());
      1: return $signed(32'($urandom_range(0, 2 * spread)) - 32'(spread));
      default: return $signed(32'($urandom_range(0, 2 * spread)) - 32'(spread)) <<< 16;
    endcase
  endfunction

  function automatic logic signed [14:0] rand_yaw();
    return 15'($signed($urandom_range(0, 25736)) - 12868);
  endfunction

  task automatic test_directed();
    send_word(OP_TICK, 0, 0, 0, 0);
    send_word(OP_START, 0, 0, 0, 0);
    send_word(OP_TICK, 0, 0, 0, 0);
    send_word(OP_POSE, 32'sh7fffffff, 32'sh80000000, 15'sd12868, 0);
    send_word(OP_TICK, 0, 0, 0, 0);
    send_word(OP_WAYPT, 32'sh80000000, 32'sh7fffffff, 0, 1);
    send_word(OP_TICK, 0, 0, 0, 0);
    send_word(OP_POSE, 0, 0, -15'sd12868, 0);
    send_word(OP_WAYPT, -32'sd65536, 0, 0, 1);
    send_word(OP_TICK, 0, 0, 0, 0);
    send_word(OP_POSE, 0, 0, 15'sd4, 0);
    send_word(OP_WAYPT, 0, 0, 0, 1);
    send_word(OP_WAYPT, -32'sd655360, 32'sd65536, 0, 0);
    send_word(OP_TICK, 0, 0, 0, 0);
    send_word(OP_TICK, 0, 0, 0, 0);
    send_word(OP_WAYPT, 32'sd65536, 32'sd65536, 0, 0);
    send_word(OP_CLEAR, 0, 0, 0, 0);
    send_word(OP_TICK, 0, 0, 0, 0);
    send_word(OP_NONE6, 32'sh7fffffff, 32'sh7fffffff, 15'h7fff, 1);
    send_word(OP_NONE7, 0, 0, 0, 0);
    send_word(OP_WAYPT, 32'sd131072, 0, -15'sd1, 1);
    send_word(OP_TICK, 0, 0, 0, 0);
    send_word(OP_STOP, 0, 0, 0, 0);
    send_word(OP_TICK, 0, 0, 0, 0);
  endtask

  task automatic test_full_path();
    drain();
    send_word(OP_START, 0, 0, 0, 0);
    for (int i = 0; i < DEPTH + 3; i++)
      send_word(OP_WAYPT, rand_pos(50), rand_pos(50), 0, i == 0);
    repeat (6) send_word(OP_TICK, 0, 0, 0, 0);
    send_word(OP_STOP, 0, 0, 0, 0);
  endtask

  task automatic random_word(int spread);
    int r;
    r = $urandom_range(0, 99);
    if (r < 12)
      send_word(OP_POSE, rand_pos(spread), rand_pos(spread), rand_yaw(),
                1'($urandom_range(0, 1)));
    else if (r < 35)
      send_word(OP_WAYPT, rand_pos(spread), rand_pos(spread), 15'($urandom()),
                $urandom_range(0, 7) == 0);
    else if (r < 80)
      send_word(OP_TICK, rand_pos(spread), rand_pos(spread), 15'($urandom()), 0);
    else if (r < 86) send_word(OP_START, 0, 0, 0, 0);
    else if (r < 89) send_word(OP_STOP, 0, 0, 0, 0);
    else if (r < 92) send_word(OP_CLEAR, 0, 0, 0, 0);
    else if (r < 95)
      send_word($urandom_range(0, 1) ? OP_NONE6 : OP_NONE7, $urandom(), $urandom(),
                15'($urandom()), 1'($urandom()));
    else if (r < 98) begin
      send_word(OP_POSE, rand_pos(spread), rand_pos(spread), rand_yaw(), 0);
      send_word(OP_START, 0, 0, 0, 0);
    end else send_word(OP_STOP, 0, 0, 0, 0);
  endtask

  task automatic test_random(int count, int spread);
    int burst;
    burst = 0;
    for (int k = 0; k < count; k++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 30));
      end
      burst--;
      random_word(spread);
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_off = 1'b1;
    send_word(OP_START, 0, 0, 0, 0);
    send_word(OP_POSE, 0, 0, 0, 0);
    for (int k = 0; k < 20; k++) begin
      send_word(OP_WAYPT, rand_pos(20), rand_pos(20), 0, 1);
      send_word(OP_TICK, 0, 0, 0, 0);
    end
    send_word(OP_STOP, 0, 0, 0, 0);
    // wait for the receiver to let go, then everything must drain
    drain();
  endtask

  // receiver: random stall pattern, plus long hold-off on request
  initial begin
    int cnt;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        cnt = 0;
        while (cnt < 3000) begin
          @(posedge clk);
          cnt++;
        end
        hold_off = 1'b0;
      end
      case (($urandom_range(0, 7)))
        0, 1: out_ready <= 1'b0;
        default: out_ready <= 1'b1;
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    cmd_t e;
    if (!rst && out_valid && out_ready) begin
      if (exp_wr == exp_rd) begin
        $error("unexpected command word %0d %0d %0d", vel_x, vel_y, vel_yaw);
        errors++;
      end else begin
        e = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        n_cmds++;
        if (vel_x !== e.vx) begin
          $error("vel_x expected %0d got %0d", e.vx, vel_x); errors++;
        end
        if (vel_y !== e.vy) begin
          $error("vel_y expected %0d got %0d", e.vy, vel_y); errors++;
        end
        if (vel_yaw !== e.vw) begin
          $error("vel_yaw expected %0d got %0d", e.vw, vel_yaw); errors++;
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("timeout");
    $display("waypoint_heading_p_controller_core_tb: done, errors");
    $finish;
  end

  initial begin
    m_gx = 655; m_gy = 655; m_gw = 655; m_turn = 8192;
    m_px = 0; m_py = 0; m_yaw = 0; m_seen = 0; m_track = 0;
    m_head = 0; m_count = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    set_gains(16'hffff, 16'hffff, 16'hffff, 16'h7fff);
    test_directed();
    set_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    test_directed();
    drain();
    write_reg(REG_BAD, 16'h1234);
    set_gains(16'd655, 16'd40000, 16'd1000, 16'd8192);
    test_full_path();
    test_random(320, 100);
    test_backpressure();
    set_gains(16'hffff, 16'h8000, 16'hffff, 16'h7fff);
    test_random(320, 30000);
    set_gains(16'd3000, 16'd3000, 16'd5000, 16'd3000);
    test_random(320, 500);
    set_gains(16'd1, 16'hffff, 16'd0, 16'd32767);
    test_random(200, 10);
    drain();
    $display("sent %0d input words, checked %0d command words", n_items, n_cmds);
    $display("covered all opcodes, full path, extreme gains and a long receiver stall");
    if (errors == 0) $display("waypoint_heading_p_controller_core_tb: done, clean");
    else $display("waypoint_heading_p_controller_core_tb: done, errors");
    $finish;
  end

endmodule

[waypoint_heading_p_controller_core.f]
+incdir+rtl/core
rtl/core/wpc_pkg.sv
rtl/core/wpc_cordic.sv
rtl/core/waypoint_heading_p_controller_core.sv
sim/waypoint_heading_p_controller_core_tb.sv
